// ----- rtl/garch_variance_filter_macros.svh -----
// Assertion macros used by the filter back end.
`ifndef GARCH_VARIANCE_FILTER_MACROS_SVH
`define GARCH_VARIANCE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GVF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GVF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gvf_pkg.sv -----
package gvf_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_MEAN  = 3'd0;
    localparam logic [2:0] REG_OMEGA = 3'd1;
    localparam logic [2:0] REG_ALPHA = 3'd2;
    localparam logic [2:0] REG_BETA  = 3'd3;
    localparam logic [2:0] REG_INIT  = 3'd4;

    // Register reset values.
    localparam logic signed [31:0] MEAN_RESET  = 32'sd0;
    localparam logic [47:0]        OMEGA_RESET = 48'd1;
    localparam logic [31:0]        ALPHA_RESET = 32'd214748365;
    localparam logic [31:0]        BETA_RESET  = 32'd3865470566;
    localparam logic [47:0]        INIT_RESET  = 48'd109951163;

    // One centred sample on its way from the front to the back.
    typedef struct packed {
        logic signed [32:0] centred;
        logic               start;
    } t_item;

    // Queue status seen by its two sides.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// ----- rtl/gvf_front.sv -----
module gvf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_return_sample,
    input  logic                i_series_start,
    input  logic signed [31:0]  i_mean_return,
    input  gvf_pkg::t_q_status  i_q_status,
    output logic                o_push,
    output gvf_pkg::t_item      o_item
);

    logic           r_valid;
    gvf_pkg::t_item r_item;
    logic           w_take;

    // The stage empties into the queue whenever the queue has room.
    assign o_push  = r_valid && !i_q_status.full;
    assign o_stall = r_valid && i_q_status.full;
    assign w_take  = i_valid && !o_stall;
    assign o_item  = r_item;

    // Centre each beat on the configured mean as it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (w_take) begin
            r_item.centred <= {i_return_sample[31], i_return_sample}
                            - {i_mean_return[31], i_mean_return};
            r_item.start   <= i_series_start;
        end
    end

endmodule

// ----- rtl/gvf_queue.sv -----
module gvf_queue #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gvf_pkg::t_item     i_item,
    input  logic               i_pop,
    output gvf_pkg::t_item     o_item,
    output gvf_pkg::t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    gvf_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;

    assign o_item          = r_mem[r_rd];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == CW'(DEPTH));

    // Circular pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ----- rtl/gvf_back.sv -----
`include "garch_variance_filter_macros.svh"

module gvf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gvf_pkg::t_item     i_item,
    input  gvf_pkg::t_q_status i_q_status,
    output logic               o_pop,
    input  logic [47:0]        i_omega_term,
    input  logic [31:0]        i_alpha_gain,
    input  logic [31:0]        i_beta_gain,
    input  logic [47:0]        i_initial_variance,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [47:0]        o_conditional_variance,
    output logic signed [31:0] o_std_residual,
    output logic               o_saturated
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MUL5,
        S_SQRT, S_DIV, S_FIN
    } t_state;

    t_state        r_state;
    logic [47:0]   r_var;
    logic [47:0]   r_h;
    logic          r_neg;
    logic [31:0]   r_ae;
    logic [63:0]   r_prod;
    logic [31:0]   r_e2hi;
    logic [95:0]   r_acc;
    logic [31:0]   r_lohi;
    logic [49:0]   r_sum;
    logic [63:0]   r_x;
    logic [34:0]   r_rem;
    logic [31:0]   r_root;
    logic [55:0]   r_num;
    logic [31:0]   r_drem;
    logic [5:0]    r_cnt;
    logic          r_out_valid;
    logic [47:0]   r_out_var;
    logic [31:0]   r_out_res;
    logic          r_out_sat;

    logic [31:0]   w_ma;
    logic [31:0]   w_mb;
    logic [63:0]   w_mp;
    logic [47:0]   w_h0;
    logic [32:0]   w_abs;
    logic [34:0]   w_rsh;
    logic [34:0]   w_trial;
    logic [32:0]   w_dsh;
    logic          w_qbit;
    logic          w_qsat;
    logic [31:0]   w_qmag;
    logic          w_hsat;
    logic [47:0]   w_hn;

    assign o_pop = (r_state == S_IDLE) && !i_q_status.empty;
    assign o_valid = r_out_valid;
    assign o_conditional_variance = r_out_var;
    assign o_std_residual = r_out_res;
    assign o_saturated = r_out_sat;

    // Variance in force for the popped item; a reload is floored at one LSB.
    assign w_h0  = i_item.start ? ((i_initial_variance == '0) ? 48'd1 : i_initial_variance)
                                : r_var;
    assign w_abs = i_item.centred[32] ? 33'(-i_item.centred) : 33'(i_item.centred);

    // Shared 32 by 32 multiplier, operands chosen by the step.
    always_comb begin
        w_ma = r_ae;
        w_mb = r_ae;
        case (r_state)
            S_MUL1: begin w_ma = i_alpha_gain; w_mb = r_prod[31:0]; end
            S_MUL2: begin w_ma = i_alpha_gain; w_mb = r_e2hi; end
            S_MUL3: begin w_ma = i_beta_gain;  w_mb = r_h[31:0]; end
            S_MUL4: begin w_ma = i_beta_gain;  w_mb = {16'd0, r_h[47:32]}; end
            default: begin w_ma = r_ae; w_mb = r_ae; end
        endcase
    end
    assign w_mp = w_ma * w_mb;

    // One root bit and one quotient bit per step.
    assign w_rsh   = {r_rem[32:0], r_x[63:62]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_dsh   = {r_drem, r_num[55]};
    assign w_qbit  = (w_dsh >= {1'b0, r_root});

    // Residual clipping and variance clipping.
    always_comb begin
        if (r_neg) begin
            w_qsat = (r_num > 56'h80000000);
            w_qmag = w_qsat ? 32'h80000000 : r_num[31:0];
        end else begin
            w_qsat = (r_num > 56'h7FFFFFFF);
            w_qmag = w_qsat ? 32'h7FFFFFFF : r_num[31:0];
        end
    end
    assign w_hsat = (r_sum[49:48] != 2'b00);
    assign w_hn   = w_hsat ? 48'hFFFFFFFFFFFF : ((r_sum[47:0] == '0) ? 48'd1 : r_sum[47:0]);

    // Sequencer, datapath registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_var       <= gvf_pkg::INIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            // The finish step reloads the output register itself.
            if (r_out_valid && !i_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_h     <= w_h0;
                        r_neg   <= i_item.centred[32];
                        r_ae    <= w_abs[31:0];
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_prod  <= w_mp;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_e2hi  <= r_prod[63:32];
                    r_prod  <= w_mp;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_acc   <= {32'd0, r_prod};
                    r_prod  <= w_mp;
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_acc   <= r_acc + {r_prod, 32'd0};
                    r_prod  <= w_mp;
                    r_state <= S_MUL4;
                end
                S_MUL4: begin
                    r_sum   <= {2'b00, i_omega_term} + {2'b00, r_acc[95:48]};
                    r_lohi  <= r_prod[63:32];
                    r_prod  <= w_mp;
                    r_state <= S_MUL5;
                end
                S_MUL5: begin
                    r_sum   <= r_sum + {2'b00, r_prod[47:0]} + {18'd0, r_lohi};
                    r_x     <= {r_h, 16'd0};
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_x <= {r_x[61:0], 2'b00};
                    if (w_rsh >= w_trial) begin
                        r_rem  <= w_rsh - w_trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= w_rsh;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    if (r_cnt == 6'd31) begin
                        r_cnt   <= '0;
                        r_num   <= {r_ae, 24'd0};
                        r_drem  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    r_num  <= {r_num[54:0], w_qbit};
                    r_drem <= w_qbit ? 32'(w_dsh - {1'b0, r_root}) : w_dsh[31:0];
                    if (r_cnt == 6'd55) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_var   <= r_h;
                        r_out_res   <= r_neg ? 32'(-w_qmag) : w_qmag;
                        r_out_sat   <= w_qsat || w_hsat;
                        r_var       <= w_hn;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `GVF_ASSERT_NOW(a_var_nonzero, i_clk, i_rst_n, 1'b1, r_var != '0, "variance state is zero")
    `GVF_ASSERT_NEXT(a_pop_starts, i_clk, i_rst_n, o_pop, r_state == S_MUL0, "pop did not start work")
    `GVF_ASSERT_NOW(a_root_range, i_clk, i_rst_n, r_state == S_DIV, r_root >= 32'd256, "root too small")
    `GVF_ASSERT_NEXT(a_out_from_fin, i_clk, i_rst_n, !r_out_valid, !o_valid || $past(r_state == S_FIN), "result without finish")

endmodule

// ----- rtl/garch_variance_filter.sv -----
// Channel  | valid    | stall    | payload
// input    | i_valid  | o_stall  | i_return_sample, i_series_start
// output   | o_valid  | i_stall  | o_conditional_variance, o_std_residual, o_saturated
// config   | i_cfg_we | none     | i_cfg_index, i_cfg_data
// Each item passes through the back end as a pop, six multiply steps on the shared
// 32 by 32 multiplier, a bit-serial square root giving 32 root bits, a bit-serial
// division giving 56 quotient bits and a finish step. The input stage and the queue
// take further beats while the back end works. Reset is synchronous, active low, and
// loads the variance state with the reset initial variance. A stalled result holds
// the back end in its finish cycle; the queue then fills and stalls the input.
module garch_variance_filter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_return_sample,
    input  logic               i_series_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [47:0]        o_conditional_variance,
    output logic signed [31:0] o_std_residual,
    output logic               o_saturated,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);

    logic signed [31:0] r_mean;
    logic [47:0]        r_omega;
    logic [31:0]        r_alpha;
    logic [31:0]        r_beta;
    logic [47:0]        r_init;

    gvf_pkg::t_item     w_push_item;
    gvf_pkg::t_item     w_pop_item;
    gvf_pkg::t_q_status w_q_status;
    logic               w_push;
    logic               w_pop;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= gvf_pkg::MEAN_RESET;
            r_omega <= gvf_pkg::OMEGA_RESET;
            r_alpha <= gvf_pkg::ALPHA_RESET;
            r_beta  <= gvf_pkg::BETA_RESET;
            r_init  <= gvf_pkg::INIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gvf_pkg::REG_MEAN:  r_mean  <= i_cfg_data[31:0];
                gvf_pkg::REG_OMEGA: r_omega <= i_cfg_data;
                gvf_pkg::REG_ALPHA: r_alpha <= i_cfg_data[31:0];
                gvf_pkg::REG_BETA:  r_beta  <= i_cfg_data[31:0];
                gvf_pkg::REG_INIT:  r_init  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gvf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_return_sample (i_return_sample),
        .i_series_start  (i_series_start),
        .i_mean_return   (r_mean),
        .i_q_status      (w_q_status),
        .o_push          (w_push),
        .o_item          (w_push_item)
    );

    gvf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_pop_item),
        .o_status (w_q_status)
    );

    gvf_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_item                 (w_pop_item),
        .i_q_status             (w_q_status),
        .o_pop                  (w_pop),
        .i_omega_term           (r_omega),
        .i_alpha_gain           (r_alpha),
        .i_beta_gain            (r_beta),
        .i_initial_variance     (r_init),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_conditional_variance (o_conditional_variance),
        .o_std_residual         (o_std_residual),
        .o_saturated            (o_saturated)
    );

endmodule

// ----- tb/sv/garch_variance_filter_tb.sv -----
`timescale 1ns / 1ps

module garch_variance_filter_tb;

    localparam logic [47:0] VAR_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [47:0] variance;
        logic [31:0] residual;
        logic        clipped;
    } t_garch_result;

    // Fixed-point GARCH(1,1) recursion with its own copy of registers and variance.
    class garch_scoreboard;
        logic signed [31:0] mean_r;
        logic [47:0]        omega_r;
        logic [31:0]        alpha_r;
        logic [31:0]        beta_r;
        logic [47:0]        init_var_r;
        logic [47:0]        var_state;
        t_garch_result      pending_results[$];
        int                 mismatches;
        int                 strays;

        function new();
            mean_r     = gvf_pkg::MEAN_RESET;
            omega_r    = gvf_pkg::OMEGA_RESET;
            alpha_r    = gvf_pkg::ALPHA_RESET;
            beta_r     = gvf_pkg::BETA_RESET;
            init_var_r = gvf_pkg::INIT_RESET;
            var_state  = floor_one(gvf_pkg::INIT_RESET);
            mismatches = 0;
            strays     = 0;
        endfunction

        function logic [47:0] floor_one(logic [47:0] v);
            return (v == 0) ? 48'd1 : v;
        endfunction

        // Register writes; indexes past the last register are dropped.
        function void set_reg(logic [2:0] idx, logic [47:0] data);
            case (idx)
                gvf_pkg::REG_MEAN:  mean_r     = data[31:0];
                gvf_pkg::REG_OMEGA: omega_r    = data;
                gvf_pkg::REG_ALPHA: alpha_r    = data[31:0];
                gvf_pkg::REG_BETA:  beta_r     = data[31:0];
                gvf_pkg::REG_INIT:  init_var_r = data;
                default: ;
            endcase
        endfunction

        // Integer square root, one result bit per step from the top.
        function logic [31:0] root64(logic [63:0] x);
            logic [31:0] r;
            r = '0;
            for (int b = 31; b >= 0; b--) begin
                r[b] = 1'b1;
                if (64'(r) * 64'(r) > x) r[b] = 1'b0;
            end
            return r;
        endfunction

        // Work out the result of one accepted sample and advance the variance.
        function void note_sample(logic signed [31:0] ret, logic start);
            logic signed [32:0] shock;
            logic [32:0]        mag;
            logic [31:0]        root;
            logic [63:0]        quot;
            logic [63:0]        sq;
            logic [95:0]        arch_term;
            logic [79:0]        garch_term;
            logic [65:0]        next_var;
            t_garch_result      res;

            if (start) var_state = floor_one(init_var_r);
            res.variance = floor_one(var_state);
            res.clipped  = 1'b0;

            shock = $signed({ret[31], ret}) - $signed({mean_r[31], mean_r});
            mag   = shock[32] ? 33'(-shock) : 33'(shock);

            root = root64({res.variance, 16'd0});
            quot = {7'd0, mag, 24'd0} / {32'd0, root};
            if (shock[32]) begin
                if (quot > 64'h8000_0000) begin
                    quot = 64'h8000_0000;
                    res.clipped = 1'b1;
                end
                res.residual = 32'(-quot);
            end else begin
                if (quot > 64'h7FFF_FFFF) begin
                    quot = 64'h7FFF_FFFF;
                    res.clipped = 1'b1;
                end
                res.residual = quot[31:0];
            end

            // Recursion terms are truncated separately, then summed exactly.
            sq         = 64'(mag) * 64'(mag);
            arch_term  = (96'(alpha_r) * 96'(sq)) >> 48;
            garch_term = (80'(beta_r) * 80'(res.variance)) >> 32;
            next_var   = 66'(omega_r) + 66'(arch_term) + 66'(garch_term);
            if (next_var > 66'(VAR_MAX)) begin
                next_var = 66'(VAR_MAX);
                res.clipped = 1'b1;
            end
            var_state = floor_one(next_var[47:0]);
            pending_results.push_back(res);
        endfunction

        // Compare one delivered beat against the oldest expectation.
        function void check_result(logic [47:0] var_out, logic [31:0] res_out, logic clip_out);
            t_garch_result want;
            if (pending_results.size() == 0) begin
                strays++;
                $display("Unexpected result beat: var=%h resid=%h sat=%b",
                         var_out, res_out, clip_out);
                return;
            end
            want = pending_results.pop_front();
            if (var_out !== want.variance || res_out !== want.residual ||
                clip_out !== want.clipped) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: var exp %h got %h, resid exp %h got %h, sat exp %b got %b",
                             want.variance, var_out, want.residual, res_out,
                             want.clipped, clip_out);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_return_sample;
    logic               i_series_start;
    logic               o_valid;
    logic               i_stall;
    logic [47:0]        o_conditional_variance;
    logic signed [31:0] o_std_residual;
    logic               o_saturated;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [47:0]        i_cfg_data;

    garch_scoreboard sb;
    bit              idle_on;
    bit              long_hold;

    garch_variance_filter i_dut (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: check every accepted beat.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_conditional_variance, o_std_residual, o_saturated);
    end

    // Result side stalls: random bursts, plus one long hold-off on request.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                long_hold = 1'b0;
                i_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Offer one sample; entered and left at a falling edge.
    task automatic send_sample(logic signed [31:0] ret, logic start);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_return_sample <= ret;
        i_series_start  <= start;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(ret, start);
        @(negedge i_clk);
    endtask

    // Let the filter drain before touching registers.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly realistic small returns, some at full scale.
    function automatic logic signed [31:0] rand_return();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed(32'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
            default: return $signed(32'($urandom_range(0, 32'h0FFF_FFFF))) - 32'sh0800_0000;
        endcase
    endfunction

    initial begin
        sb              = new();
        idle_on         = 1'b1;
        long_hold       = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_return_sample = '0;
        i_series_start  = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset settings: state carried from reset, extremes, series restart.
        send_sample(32'sd0, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh0100_0000, 1'b1);
        send_sample(-32'sh0100_0000, 1'b0);
        send_sample(32'sd1, 1'b0);

        // Every register but the mean at its top, the mean at its most negative: the variance overflows and clips.
        wait_drained();
        write_reg(gvf_pkg::REG_MEAN, 48'hABCD_8000_0000);
        write_reg(gvf_pkg::REG_OMEGA, VAR_MAX);
        write_reg(gvf_pkg::REG_ALPHA, 48'hFFFF_FFFF_FFFF);
        write_reg(gvf_pkg::REG_BETA, 48'h0000_FFFF_FFFF);
        write_reg(gvf_pkg::REG_INIT, VAR_MAX);
        i_cfg_we <= 1'b0;
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(32'sh1234_5678, 1'b0);

        // Minimum variance and extreme mean: the residual clips; gains at zero.
        wait_drained();
        write_reg(gvf_pkg::REG_MEAN, 48'h0000_7FFF_FFFF);
        write_reg(gvf_pkg::REG_OMEGA, 48'd1);
        write_reg(gvf_pkg::REG_ALPHA, 48'd0);
        write_reg(gvf_pkg::REG_BETA, 48'd0);
        write_reg(gvf_pkg::REG_INIT, 48'd1);
        write_reg(3'd5, rand48());
        write_reg(3'd6, rand48());
        write_reg(3'd7, rand48());
        i_cfg_we <= 1'b0;
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh7FFF_FFFE, 1'b0);
        send_sample(32'sh0000_0000, 1'b0);
        // Initial variance rewritten: old state holds until the next start.
        wait_drained();
        write_reg(gvf_pkg::REG_INIT, 48'h00FF_0000_0000);
        i_cfg_we <= 1'b0;
        send_sample(32'sh7FFF_0000, 1'b0);
        send_sample(32'sh7FFF_0000, 1'b1);
        send_sample(32'sh0000_1000, 1'b0);

        // Random phases, each with freshly drawn registers.
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            write_reg(gvf_pkg::REG_MEAN, $urandom_range(0, 1) ? rand48()
                                : 48'($signed(32'($urandom_range(0, 32'h00FF_FFFF)))
                                      - 32'sh0080_0000));
            write_reg(gvf_pkg::REG_OMEGA, $urandom_range(0, 2) == 0 ? rand48()
                                 : 48'($urandom_range(1, 32'h00FF_FFFF)));
            write_reg(gvf_pkg::REG_ALPHA, rand48());
            write_reg(gvf_pkg::REG_BETA, $urandom_range(0, 1) ? rand48()
                                         : 48'(gvf_pkg::BETA_RESET));
            write_reg(gvf_pkg::REG_INIT, $urandom_range(0, 3) == 0 ? rand48()
                                : 48'($urandom_range(1, 32'h7FFF_FFFF)));
            if ($urandom_range(0, 1)) write_reg(3'($urandom_range(5, 7)), rand48());
            i_cfg_we <= 1'b0;
            if (ph == 3) long_hold = 1'b1;
            if (ph == 7) idle_on = 1'b0;
            for (int n = 0; n < 148; n++)
                send_sample(rand_return(), ($urandom_range(0, 19) == 0) || n == 0);
        end
        i_valid <= 1'b0;

        // Drain and report.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.strays == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/gvf_pkg.sv
rtl/gvf_front.sv
rtl/gvf_queue.sv
rtl/gvf_back.sv
rtl/garch_variance_filter.sv
tb/sv/garch_variance_filter_tb.sv
